>>> hdl/tbp_pkg.sv
package tbp_pkg;

    // table sizes, all powers of two
    localparam int LOCAL_HIST_ENTRIES     = 16384;
    localparam int LOCAL_COUNTER_ENTRIES  = 8192;
    localparam int GLOBAL_COUNTER_ENTRIES = 65536;
    localparam int COUNTER_WIDTH          = 2;
    localparam int PC_SHIFT               = 2;
    localparam int PC_WIDTH               = 64;

    // index widths
    localparam int LH_AW = $clog2(LOCAL_HIST_ENTRIES);
    localparam int LC_AW = $clog2(LOCAL_COUNTER_ENTRIES);
    localparam int GC_AW = $clog2(GLOBAL_COUNTER_ENTRIES);

    // clearing pass covers the deepest table
    localparam int CLR_DEPTH_A = (LOCAL_HIST_ENTRIES > LOCAL_COUNTER_ENTRIES) ?
                                 LOCAL_HIST_ENTRIES : LOCAL_COUNTER_ENTRIES;
    localparam int CLR_DEPTH   = (CLR_DEPTH_A > GLOBAL_COUNTER_ENTRIES) ?
                                 CLR_DEPTH_A : GLOBAL_COUNTER_ENTRIES;
    localparam int CLR_W       = $clog2(CLR_DEPTH);

    typedef logic [COUNTER_WIDTH-1:0] t_ctr;

    localparam t_ctr CTR_MAX = {COUNTER_WIDTH{1'b1}};
    localparam t_ctr CTR_MIN = '0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_LH,
        ST_RD_LC
    } t_state;

    // training results for one branch
    typedef struct packed {
        logic pred;
        logic correct;
        t_ctr lc_new;
        t_ctr gc_new;
        t_ctr ch_new;
    } t_upd;

    // saturating step toward the given direction
    function automatic t_ctr ctr_train(input t_ctr c, input logic up);
        t_ctr r;
        r = c;
        if (up) begin
            if (c != CTR_MAX) r = c + t_ctr'(1);
        end else begin
            if (c != CTR_MIN) r = c - t_ctr'(1);
        end
        return r;
    endfunction

endpackage

>>> hdl/tbp_ram.sv
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tbp_update.sv
module tbp_update (
    input  tbp_pkg::t_ctr i_lc,
    input  tbp_pkg::t_ctr i_gc,
    input  tbp_pkg::t_ctr i_ch,
    input  logic          i_taken,
    output tbp_pkg::t_upd o_upd
);
    import tbp_pkg::*;

    logic local_p;
    logic global_p;
    logic use_global;
    logic final_p;

    // direction bits
    assign local_p    = i_lc[COUNTER_WIDTH-1];
    assign global_p   = i_gc[COUNTER_WIDTH-1];
    assign use_global = i_ch[COUNTER_WIDTH-1];
    assign final_p    = use_global ? global_p : local_p;

    // prediction and trained counters
    always_comb begin
        o_upd.pred    = final_p;
        o_upd.correct = (final_p == i_taken);
        o_upd.lc_new  = ctr_train(i_lc, i_taken);
        o_upd.gc_new  = ctr_train(i_gc, i_taken);
        // chooser moves only when the two sides disagree
        if (local_p != global_p) begin
            o_upd.ch_new = ctr_train(i_ch, global_p == i_taken);
        end else begin
            o_upd.ch_new = i_ch;
        end
    end

endmodule

>>> hdl/tournament_branch_predictor_core.sv
// the result beat is registered after the local history read, the local counter read and write-back
// a new branch is accepted only in idle, after the previous one has done the dependent reads of the
//   local history table and then the local counter table and its write-back
// a result waiting at the output stalls the write-back of the next branch, and with it the input
// reset: a clearing pass zeroes every entry of all tables, no input accepted
module tournament_branch_predictor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tbp_pkg::PC_WIDTH-1:0]  i_branch_pc,
    input  logic                          i_taken,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_predicted_taken,
    output logic                          o_pred_hit
);
    import tbp_pkg::*;

    t_state r_state, n_state;
    logic [CLR_W-1:0] r_clr, n_clr;
    logic [LH_AW-1:0] r_lh_idx;
    logic             r_taken;
    logic [GC_AW-1:0] r_ghist;
    logic             r_out_valid;
    logic             r_pred;
    logic             r_corr;

    logic             in_fire;
    logic             upd_fire;
    logic             clr_on;

    // memory ports
    logic             lh_we, lh_re;
    logic [LH_AW-1:0] lh_waddr, lh_raddr;
    logic [LC_AW-1:0] lh_wdata, lh_rdata;
    logic             lc_we, lc_re;
    logic [LC_AW-1:0] lc_waddr, lc_raddr;
    t_ctr             lc_wdata, lc_rdata;
    logic             gc_we, gc_re;
    logic [GC_AW-1:0] gc_waddr, gc_raddr;
    logic [2*COUNTER_WIDTH-1:0] gc_wdata, gc_rdata;

    t_upd             upd;

    // local history table and counter tables
    tbp_ram #(.WIDTH(LC_AW), .DEPTH(LOCAL_HIST_ENTRIES)) u_lh_ram (
        .i_clk(i_clk), .i_we(lh_we), .i_waddr(lh_waddr), .i_wdata(lh_wdata),
        .i_re(lh_re), .i_raddr(lh_raddr), .o_rdata(lh_rdata)
    );

    tbp_ram #(.WIDTH(COUNTER_WIDTH), .DEPTH(LOCAL_COUNTER_ENTRIES)) u_lc_ram (
        .i_clk(i_clk), .i_we(lc_we), .i_waddr(lc_waddr), .i_wdata(lc_wdata),
        .i_re(lc_re), .i_raddr(lc_raddr), .o_rdata(lc_rdata)
    );

    // global counter and chooser share the global history index
    tbp_ram #(.WIDTH(2*COUNTER_WIDTH), .DEPTH(GLOBAL_COUNTER_ENTRIES)) u_gc_ram (
        .i_clk(i_clk), .i_we(gc_we), .i_waddr(gc_waddr), .i_wdata(gc_wdata),
        .i_re(gc_re), .i_raddr(gc_raddr), .o_rdata(gc_rdata)
    );

    tbp_update u_update (
        .i_lc   (lc_rdata),
        .i_gc   (gc_rdata[2*COUNTER_WIDTH-1:COUNTER_WIDTH]),
        .i_ch   (gc_rdata[COUNTER_WIDTH-1:0]),
        .i_taken(r_taken),
        .o_upd  (upd)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign upd_fire   = (r_state == ST_RD_LC) && (!r_out_valid || i_out_ready);
    assign clr_on     = (r_state == ST_CLEAR);

    // next state and memory control
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        lh_re    = 1'b0;
        lh_raddr = i_branch_pc[PC_SHIFT +: LH_AW];
        gc_re    = 1'b0;
        gc_raddr = r_ghist;
        lc_re    = 1'b0;
        lc_raddr = lh_rdata;
        lh_we    = 1'b0;
        lc_we    = 1'b0;
        gc_we    = 1'b0;
        lh_waddr = r_lh_idx;
        lh_wdata = LC_AW'({lh_rdata, r_taken});
        lc_waddr = lh_rdata;
        lc_wdata = upd.lc_new;
        gc_waddr = r_ghist;
        gc_wdata = {upd.gc_new, upd.ch_new};
        unique case (r_state)
            ST_CLEAR: begin
                lh_we    = 1'b1;
                lc_we    = 1'b1;
                gc_we    = 1'b1;
                lh_waddr = r_clr[LH_AW-1:0];
                lc_waddr = r_clr[LC_AW-1:0];
                gc_waddr = r_clr[GC_AW-1:0];
                lh_wdata = '0;
                lc_wdata = '0;
                gc_wdata = '0;
                n_clr    = r_clr + CLR_W'(1);
                if (r_clr == CLR_W'(CLR_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    lh_re   = 1'b1;
                    gc_re   = 1'b1;
                    n_state = ST_RD_LH;
                end
            end
            ST_RD_LH: begin
                lc_re   = 1'b1;
                n_state = ST_RD_LC;
            end
            ST_RD_LC: begin
                if (upd_fire) begin
                    lh_we   = 1'b1;
                    lc_we   = 1'b1;
                    gc_we   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_ghist     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (upd_fire) begin
                r_ghist     <= GC_AW'({r_ghist, r_taken});
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_lh_idx <= i_branch_pc[PC_SHIFT +: LH_AW];
            r_taken  <= i_taken;
        end
        if (upd_fire) begin
            r_pred <= upd.pred;
            r_corr <= upd.correct;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_predicted_taken = r_pred;
    assign o_pred_hit        = r_corr;

    // accepted beat starts the history read
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_RD_LH))
        else $error("accepted beat did not start table reads");

    // result flag agrees with the captured outcome
    a_correct_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_fire |=> (o_pred_hit == (o_predicted_taken == $past(r_taken))))
        else $error("pred_hit inconsistent with outcome");

    // global history takes in the outcome on write-back
    a_ghist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_fire |=> (r_ghist[0] == $past(r_taken)))
        else $error("global history missed outcome");

    // no result and no input ready while tables are being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_on |-> (!o_out_valid && !o_in_ready))
        else $error("activity during clearing pass");

endmodule

>>> dv/tournament_branch_predictor_core_test.sv
module tournament_branch_predictor_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tbp_pkg::*;

    localparam int POOL_SIZE   = 12;
    localparam int HOLD_CYCLES = 300;

    // behavior of one branch in the trace pool
    typedef enum int {
        BR_ALWAYS,
        BR_NEVER,
        BR_LOOP,
        BR_ALT,
        BR_RANDOM
    } t_br_kind;

    // what the block should report for one branch
    typedef struct packed {
        logic pred;
        logic correct;
    } t_outcome;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [PC_WIDTH-1:0] i_branch_pc = '0;
    logic                i_taken = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_predicted_taken;
    logic                o_pred_hit;

    // shadow copy of the predictor tables
    logic [LC_AW-1:0] lhist_tbl  [LOCAL_HIST_ENTRIES];
    t_ctr             lctr_tbl   [LOCAL_COUNTER_ENTRIES];
    t_ctr             gctr_tbl   [GLOBAL_COUNTER_ENTRIES];
    t_ctr             choice_tbl [GLOBAL_COUNTER_ENTRIES];
    logic [GC_AW-1:0] ghist;

    t_outcome outcome_q[$];

    // trace pool
    logic [PC_WIDTH-1:0] pool_pc     [POOL_SIZE];
    t_br_kind            pool_kind   [POOL_SIZE];
    int                  pool_period [POOL_SIZE];
    int                  pool_iter   [POOL_SIZE];

    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;
    int rx_hold_left = 0;

    int n_sent    = 0;
    int n_checked = 0;
    int n_right   = 0;
    int n_fail    = 0;

    tournament_branch_predictor_core i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_branch_pc          (i_branch_pc),
        .i_taken              (i_taken),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_predicted_taken    (o_predicted_taken),
        .o_pred_hit           (o_pred_hit)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // saturating counter step
    function automatic t_ctr step_counter(input t_ctr c, input logic up);
        t_ctr r;
        r = c;
        if (up) begin
            if (c != {COUNTER_WIDTH{1'b1}}) r = c + 1'b1;
        end else begin
            if (c != '0) r = c - 1'b1;
        end
        return r;
    endfunction

    // predict then train the shadow tables for one resolved branch
    function automatic t_outcome predict_branch(input logic [PC_WIDTH-1:0] pc, input logic tk);
        logic [LH_AW-1:0] lh_idx;
        logic [LC_AW-1:0] lc_idx;
        logic [GC_AW-1:0] g_idx;
        logic             local_dir;
        logic             global_dir;
        logic             final_dir;
        t_outcome         r;
        lh_idx     = pc[PC_SHIFT +: LH_AW];
        lc_idx     = lhist_tbl[lh_idx];
        g_idx      = ghist;
        local_dir  = lctr_tbl[lc_idx][COUNTER_WIDTH-1];
        global_dir = gctr_tbl[g_idx][COUNTER_WIDTH-1];
        final_dir  = choice_tbl[g_idx][COUNTER_WIDTH-1] ? global_dir : local_dir;
        // chooser only learns when the two sides disagree
        if (local_dir != global_dir)
            choice_tbl[g_idx] = step_counter(choice_tbl[g_idx], global_dir == tk);
        gctr_tbl[g_idx]   = step_counter(gctr_tbl[g_idx], tk);
        lctr_tbl[lc_idx]  = step_counter(lctr_tbl[lc_idx], tk);
        ghist             = {ghist[GC_AW-2:0], tk};
        lhist_tbl[lh_idx] = {lhist_tbl[lh_idx][LC_AW-2:0], tk};
        r.pred    = final_dir;
        r.correct = (final_dir == tk);
        return r;
    endfunction

    task automatic clear_tables();
        for (int i = 0; i < LOCAL_HIST_ENTRIES; i++) lhist_tbl[i] = '0;
        for (int i = 0; i < LOCAL_COUNTER_ENTRIES; i++) lctr_tbl[i] = '0;
        for (int i = 0; i < GLOBAL_COUNTER_ENTRIES; i++) begin
            gctr_tbl[i]   = '0;
            choice_tbl[i] = '0;
        end
        ghist = '0;
    endtask

    // offer one branch beat, with a random gap in front of it when sender idling is enabled
    task automatic send_branch(input logic [PC_WIDTH-1:0] pc, input logic tk);
        int gap;
        gap = 0;
        if (tx_idle_en) begin
            while ($urandom_range(99) < 27) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_branch_pc <= pc;
        i_taken     <= tk;
        do @(posedge i_clk); while (!o_in_ready);
        outcome_q.push_back(predict_branch(pc, tk));
        n_sent++;
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (outcome_q.size() > 0) @(posedge i_clk);
    endtask

    task automatic build_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_pc[i]     = {$urandom, $urandom};
            pool_kind[i]   = t_br_kind'(i % 5);
            pool_period[i] = $urandom_range(8, 2);
            pool_iter[i]   = 0;
        end
    endtask

    function automatic logic next_outcome(input int idx);
        logic r;
        pool_iter[idx]++;
        case (pool_kind[idx])
            BR_ALWAYS: r = 1'b1;
            BR_NEVER:  r = 1'b0;
            BR_LOOP:   r = (pool_iter[idx] % pool_period[idx]) != 0;
            BR_ALT:    r = pool_iter[idx][0];
            default:   r = 1'($urandom_range(1));
        endcase
        return r;
    endfunction

    // program-like trace over the pool, with some stray random branches
    task automatic run_trace(input int count, input int noise_pct);
        int pick;
        pick = 0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                send_branch({$urandom, $urandom}, 1'($urandom_range(1)));
            end else begin
                if ($urandom_range(99) < 80) pick = (pick + 1) % POOL_SIZE;
                else pick = $urandom_range(POOL_SIZE - 1);
                send_branch(pool_pc[pick], next_outcome(pick));
            end
        end
    endtask

    // pc extremes, aliasing, word offset and a repeated branch
    task automatic test_directed();
        send_branch('0, 1'b0);
        send_branch('0, 1'b1);
        send_branch('1, 1'b1);
        send_branch('1, 1'b0);
        // upper pc bits and word offset alias onto the same history entry, the next word onto its neighbour
        send_branch({1'b1, {(PC_WIDTH-1){1'b0}}}, 1'b1);
        send_branch(64'h1, 1'b1);
        send_branch(64'h2, 1'b0);
        send_branch(64'h3, 1'b1);
        send_branch(64'h4, 1'b1);
        // run one branch taken repeatedly, then not taken repeatedly
        repeat (7) send_branch(64'h100, 1'b1);
        repeat (7) send_branch(64'h100, 1'b0);
    endtask

    task automatic test_trace();
        build_pool();
        run_trace(600, 15);
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        rx_hold_left = HOLD_CYCLES;
        run_trace(40, 10);
    endtask

    // sender stops mid-stream until everything is back
    task automatic test_drain_pause();
        run_trace(30, 20);
        drain_results();
        run_trace(30, 20);
    endtask

    // back-to-back beats with no idling on either side
    task automatic test_steady();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        build_pool();
        run_trace(100, 10);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // receiver ready, random idling plus an optional long hold-off
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (rx_idle_en) begin
            i_out_ready <= ($urandom_range(99) >= 27);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // compare each result beat with the oldest outstanding prediction
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (outcome_q.size() == 0) begin
                $error("result beat with no branch outstanding");
                n_fail++;
            end else begin
                want = outcome_q.pop_front();
                n_checked++;
                if (o_pred_hit) n_right++;
                if (o_predicted_taken !== want.pred) begin
                    $error("predicted_taken: expected %0b, got %0b",
                           want.pred, o_predicted_taken);
                    n_fail++;
                end
                if (o_pred_hit !== want.correct) begin
                    $error("pred_hit: expected %0b, got %0b",
                           want.correct, o_pred_hit);
                    n_fail++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        clear_tables();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_trace();
        test_backpressure();
        test_drain_pause();
        test_steady();

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("covered: %0d branches sent, %0d results checked, %0d predicted right",
                 n_sent, n_checked, n_right);
        $display("phases: directed, pool trace, receiver hold-off, mid-run drain, steady stream");
        if (n_fail == 0 && outcome_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
